// ----- rtl/drmt_pkg.sv -----
`default_nettype none
package drmt_pkg;

    localparam int MAX_RECTS  = 16;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W      = $clog2(MAX_RECTS + 1);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int ACC_W      = PROD_W + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [ACC_W-1:0]      acc_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic [IDX_W-1:0]             idx_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        coord_t l;
        coord_t t;
        coord_t r;
        coord_t b;
    } rect_t;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_DUMP  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        AD_I,
        AD_N,
        AD_BEST
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_NR,
        WD_RD,
        WD_GROW
    } wd_sel_t;

    typedef enum logic [1:0] {
        MUL_MERGE,
        MUL_SELF,
        MUL_OVER
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB,
        ACC_ADDOV
    } acc_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD_INIT,
        ST_SCAN,
        ST_MOVE,
        ST_APPEND,
        ST_FIN,
        ST_COST_D,
        ST_COST_M0,
        ST_COST_M1,
        ST_COST_M2,
        ST_COST_M3,
        ST_COST_CMP,
        ST_GROW,
        ST_CLEAN,
        ST_CMOVE,
        ST_EMIT_BOX,
        ST_DUMP
    } state_t;

    typedef struct packed {
        logic      load;
        logic      bbox_clr;
        logic      bbox_grow;
        logic      count_clr;
        logic      count_ld;
        logic      i_clr;
        logic      i_inc;
        logic      n_load;
        logic      n_dec;
        logic      n_inc;
        logic      found_set;
        logic      found_clr;
        addr_sel_t rd_sel;
        logic      wr_en;
        addr_sel_t wr_sel;
        wd_sel_t   wd_sel;
        logic      diff_ld;
        mul_sel_t  mul_sel;
        logic      prod_ld;
        acc_op_t   acc_op;
        logic      best_upd;
        logic      g_ld;
        logic      best_fix;
        logic      emit_box;
        logic      emit_entry;
    } cmd_t;

    typedef struct packed {
        logic i_lt_n;
        logic i_last;
        logic nr_in_e;
        logic e_in_nr;
        logic found;
        logic n_lt_max;
        logic clean_hit;
        logic dump_last;
        logic count_zero;
    } status_t;

    function automatic logic inside_f(rect_t a, rect_t b);
        return ($signed(a.l) >= $signed(b.l)) && ($signed(a.t) >= $signed(b.t)) &&
               ($signed(a.r) <= $signed(b.r)) && ($signed(a.b) <= $signed(b.b));
    endfunction

    function automatic coord_t min_f(coord_t a, coord_t b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    function automatic coord_t max_f(coord_t a, coord_t b);
        return ($signed(a) > $signed(b)) ? a : b;
    endfunction

    function automatic diff_t sub_f(coord_t a, coord_t b);
        return diff_t'($signed(a)) - diff_t'($signed(b));
    endfunction

    function automatic rect_t grow_f(rect_t a, rect_t b);
        rect_t g;
        g.l = min_f(a.l, b.l);
        g.t = min_f(a.t, b.t);
        g.r = max_f(a.r, b.r);
        g.b = max_f(a.b, b.b);
        return g;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/drmt_ctrl.sv -----
`default_nettype none
module drmt_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire [1:0]            opcode,
    input  drmt_pkg::status_t    status,
    output drmt_pkg::cmd_t       cmd,
    output logic                 busy
);
    import drmt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = AD_I;
        cmd.wr_sel = AD_I;
        cmd.wd_sel = WD_NR;
        cmd.mul_sel = MUL_MERGE;
        cmd.acc_op = ACC_HOLD;
        state_next = state_reg;
        busy       = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (opcode)
                        OP_CLEAR:
                        begin
                            cmd.bbox_clr  = 1'b1;
                            cmd.count_clr = 1'b1;
                            state_next    = ST_EMIT_BOX;
                        end
                        OP_ADD:   state_next = ST_ADD_INIT;
                        OP_DUMP:
                        begin
                            cmd.i_clr  = 1'b1;
                            state_next = status.count_zero ? ST_EMIT_BOX : ST_DUMP;
                        end
                        default:  state_next = ST_EMIT_BOX;
                    endcase
                end
            end
            ST_ADD_INIT:
            begin
                cmd.bbox_grow = 1'b1;
                cmd.i_clr     = 1'b1;
                cmd.n_load    = 1'b1;
                cmd.found_clr = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!status.i_lt_n)
                begin
                    if (status.found)
                    begin
                        cmd.count_ld = 1'b1;
                        state_next   = ST_EMIT_BOX;
                    end
                    else if (status.n_lt_max)
                    begin
                        state_next = ST_APPEND;
                    end
                    else
                    begin
                        cmd.i_clr  = 1'b1;
                        state_next = ST_COST_D;
                    end
                end
                else if (status.nr_in_e)
                begin
                    cmd.count_ld = 1'b1;
                    state_next   = ST_EMIT_BOX;
                end
                else if (status.e_in_nr)
                begin
                    if (status.found)
                    begin
                        cmd.n_dec  = 1'b1;
                        state_next = ST_MOVE;
                    end
                    else
                    begin
                        cmd.wr_en     = 1'b1;
                        cmd.found_set = 1'b1;
                        cmd.i_inc     = 1'b1;
                    end
                end
                else
                begin
                    cmd.i_inc = 1'b1;
                end
            end
            ST_MOVE:
            begin
                cmd.rd_sel = AD_N;
                cmd.wr_en  = 1'b1;
                cmd.wd_sel = WD_RD;
                state_next = ST_SCAN;
            end
            ST_APPEND:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = AD_N;
                cmd.n_inc  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.count_ld = 1'b1;
                state_next   = ST_EMIT_BOX;
            end
            ST_COST_D:
            begin
                cmd.diff_ld = 1'b1;
                state_next  = ST_COST_M0;
            end
            ST_COST_M0:
            begin
                cmd.mul_sel = MUL_MERGE;
                cmd.prod_ld = 1'b1;
                state_next  = ST_COST_M1;
            end
            ST_COST_M1:
            begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MUL_SELF;
                cmd.prod_ld = 1'b1;
                state_next  = ST_COST_M2;
            end
            ST_COST_M2:
            begin
                cmd.acc_op  = ACC_SUB;
                cmd.mul_sel = MUL_OVER;
                cmd.prod_ld = 1'b1;
                state_next  = ST_COST_M3;
            end
            ST_COST_M3:
            begin
                cmd.acc_op = ACC_ADDOV;
                state_next = ST_COST_CMP;
            end
            ST_COST_CMP:
            begin
                cmd.best_upd = 1'b1;
                cmd.i_inc    = 1'b1;
                state_next   = status.i_last ? ST_GROW : ST_COST_D;
            end
            ST_GROW:
            begin
                cmd.rd_sel = AD_BEST;
                cmd.wr_sel = AD_BEST;
                cmd.wr_en  = 1'b1;
                cmd.wd_sel = WD_GROW;
                cmd.g_ld   = 1'b1;
                cmd.i_clr  = 1'b1;
                state_next = ST_CLEAN;
            end
            ST_CLEAN:
            begin
                if (!status.i_lt_n)
                begin
                    cmd.count_ld = 1'b1;
                    state_next   = ST_EMIT_BOX;
                end
                else if (status.clean_hit)
                begin
                    cmd.n_dec  = 1'b1;
                    state_next = ST_CMOVE;
                end
                else
                begin
                    cmd.i_inc = 1'b1;
                end
            end
            ST_CMOVE:
            begin
                cmd.rd_sel   = AD_N;
                cmd.wr_en    = 1'b1;
                cmd.wd_sel   = WD_RD;
                cmd.best_fix = 1'b1;
                state_next   = ST_CLEAN;
            end
            ST_EMIT_BOX:
            begin
                cmd.emit_box = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_DUMP:
            begin
                cmd.emit_entry = 1'b1;
                cmd.i_inc      = 1'b1;
                if (status.dump_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/drmt_datapath.sv -----
`default_nettype none
module drmt_datapath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  drmt_pkg::cmd_t       cmd,
    input  drmt_pkg::coord_t     rect_left,
    input  drmt_pkg::coord_t     rect_top,
    input  drmt_pkg::coord_t     rect_right,
    input  drmt_pkg::coord_t     rect_bottom,
    output drmt_pkg::status_t    status,
    output drmt_pkg::coord_t     out_left,
    output drmt_pkg::coord_t     out_top,
    output drmt_pkg::coord_t     out_right,
    output drmt_pkg::coord_t     out_bottom,
    output logic [4:0]           entry_count,
    output logic                 is_entry,
    output logic                 last,
    output logic                 result_valid
);
    import drmt_pkg::*;

    rect_t store_reg [MAX_RECTS];
    rect_t nr_reg, bbox_reg, bbox_next, g_reg;
    cnt_t  count_reg, i_reg, n_reg;
    idx_t  best_reg, best_next;
    logic  found_reg;
    diff_t mw_reg, mh_reg, sw_reg, sh_reg, ow_reg, oh_reg;
    logic  ov_reg;
    prod_t prod_reg, prod_next;
    acc_t  acc_reg, acc_next, best_cost_reg;
    rect_t out_reg;
    cnt_t  out_cnt_reg;
    logic  out_ent_reg, out_last_reg, valid_reg;

    idx_t  rd_addr, wr_addr;
    rect_t rd, wd, grown;
    diff_t ma, mb;

    function automatic idx_t addr_f(addr_sel_t s, cnt_t i, cnt_t n, idx_t best);
        case (s)
            AD_I:    return i[IDX_W-1:0];
            AD_N:    return n[IDX_W-1:0];
            AD_BEST: return best;
            default: return i[IDX_W-1:0];
        endcase
    endfunction

    assign rd_addr = addr_f(cmd.rd_sel, i_reg, n_reg, best_reg);
    assign wr_addr = addr_f(cmd.wr_sel, i_reg, n_reg, best_reg);
    assign rd      = store_reg[rd_addr];
    assign grown   = grow_f(nr_reg, rd);

    always_comb
    begin
        case (cmd.wd_sel)
            WD_NR:   wd = nr_reg;
            WD_RD:   wd = rd;
            WD_GROW: wd = grown;
            default: wd = nr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            store_reg[wr_addr] <= wd;
        end
    end

    // status
    assign status.i_lt_n     = (i_reg < n_reg);
    assign status.i_last     = (i_reg == n_reg - cnt_t'(1));
    assign status.nr_in_e    = inside_f(nr_reg, rd);
    assign status.e_in_nr    = inside_f(rd, nr_reg);
    assign status.found      = found_reg;
    assign status.n_lt_max   = (n_reg < cnt_t'(MAX_RECTS));
    assign status.clean_hit  = (i_reg[IDX_W-1:0] != best_reg) && inside_f(rd, g_reg);
    assign status.dump_last  = (i_reg == count_reg - cnt_t'(1));
    assign status.count_zero = (count_reg == '0);

    always_comb
    begin
        bbox_next = bbox_reg;
        if (cmd.bbox_clr)
        begin
            bbox_next = '{l: COORD_MAX, t: COORD_MAX, r: COORD_MIN, b: COORD_MIN};
        end
        else if (cmd.bbox_grow)
        begin
            bbox_next = grow_f(nr_reg, bbox_reg);
        end
    end

    // one shared multiplier, operands picked per cost step
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_MERGE:
            begin
                ma = mw_reg;
                mb = mh_reg;
            end
            MUL_SELF:
            begin
                ma = sw_reg;
                mb = sh_reg;
            end
            MUL_OVER:
            begin
                ma = ow_reg;
                mb = oh_reg;
            end
            default:
            begin
                ma = mw_reg;
                mb = mh_reg;
            end
        endcase
        prod_next = prod_t'(ma) * prod_t'(mb);
    end

    always_comb
    begin
        case (cmd.acc_op)
            ACC_LOAD:  acc_next = acc_t'(prod_reg);
            ACC_SUB:   acc_next = acc_reg - acc_t'(prod_reg);
            ACC_ADDOV: acc_next = ov_reg ? acc_reg + acc_t'(prod_reg) : acc_reg;
            default:   acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        best_next = best_reg;
        if (cmd.best_upd && ((i_reg == '0) || (acc_reg < best_cost_reg)))
        begin
            best_next = i_reg[IDX_W-1:0];
        end
        else if (cmd.best_fix && (n_reg[IDX_W-1:0] == best_reg))
        begin
            best_next = i_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bbox_reg  <= '{l: COORD_MAX, t: COORD_MAX, r: COORD_MIN, b: COORD_MIN};
            valid_reg <= 1'b0;
        end
        else
        begin
            bbox_reg  <= bbox_next;
            valid_reg <= cmd.emit_box | cmd.emit_entry;
            if (cmd.count_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.count_ld)
            begin
                count_reg <= n_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            nr_reg <= '{l: rect_left, t: rect_top, r: rect_right, b: rect_bottom};
        end
        if (cmd.i_clr)
        begin
            i_reg <= '0;
        end
        else if (cmd.i_inc)
        begin
            i_reg <= i_reg + cnt_t'(1);
        end
        if (cmd.n_load)
        begin
            n_reg <= count_reg;
        end
        else if (cmd.n_dec)
        begin
            n_reg <= n_reg - cnt_t'(1);
        end
        else if (cmd.n_inc)
        begin
            n_reg <= n_reg + cnt_t'(1);
        end
        if (cmd.found_clr)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.found_set)
        begin
            found_reg <= 1'b1;
        end
        if (cmd.diff_ld)
        begin
            mw_reg <= sub_f(max_f(nr_reg.r, rd.r), min_f(nr_reg.l, rd.l));
            mh_reg <= sub_f(max_f(nr_reg.b, rd.b), min_f(nr_reg.t, rd.t));
            sw_reg <= sub_f(rd.r, rd.l);
            sh_reg <= sub_f(rd.b, rd.t);
            ow_reg <= sub_f(min_f(nr_reg.r, rd.r), max_f(nr_reg.l, rd.l));
            oh_reg <= sub_f(min_f(nr_reg.b, rd.b), max_f(nr_reg.t, rd.t));
            ov_reg <= ($signed(nr_reg.r) > $signed(rd.l)) && ($signed(nr_reg.l) < $signed(rd.r)) &&
                      ($signed(nr_reg.b) > $signed(rd.t)) && ($signed(nr_reg.t) < $signed(rd.b));
        end
        if (cmd.prod_ld)
        begin
            prod_reg <= prod_next;
        end
        acc_reg  <= acc_next;
        best_reg <= best_next;
        if (cmd.best_upd && ((i_reg == '0) || (acc_reg < best_cost_reg)))
        begin
            best_cost_reg <= acc_reg;
        end
        if (cmd.g_ld)
        begin
            g_reg <= grown;
        end
        if (cmd.emit_box)
        begin
            out_reg      <= bbox_reg;
            out_cnt_reg  <= count_reg;
            out_ent_reg  <= 1'b0;
            out_last_reg <= 1'b1;
        end
        else if (cmd.emit_entry)
        begin
            out_reg      <= rd;
            out_cnt_reg  <= count_reg;
            out_ent_reg  <= 1'b1;
            out_last_reg <= status.dump_last;
        end
    end

    assign out_left     = out_reg.l;
    assign out_top      = out_reg.t;
    assign out_right    = out_reg.r;
    assign out_bottom   = out_reg.b;
    assign entry_count  = 5'(out_cnt_reg);
    assign is_entry     = out_ent_reg;
    assign last         = out_last_reg;
    assign result_valid = valid_reg;

endmodule
`default_nettype wire

// ----- rtl/dirty_rect_merge_tracker.sv -----
`default_nettype none
// Dirty-rectangle tracker: a command is taken when start is high and busy low, and every
// result appears for one cycle with result_valid high; the receiver cannot stall, so take
// each beat as it comes. Clear and unknown opcodes give one bounding-box beat through
// ST_EMIT_BOX and the output register. Add walks the stored list one entry a cycle, save
// where a removal moves the last entry into the freed slot, then, when the list is full,
// works out each entry's merge cost in ST_COST_D, ST_COST_M0..M3 and ST_COST_CMP through
// one shared multiplier, grows the cheapest entry and rescans once more to remove the
// entries inside it. Dump streams one entry beat per cycle, the final one flagged by
// last; with an empty list it gives the bounding-box beat instead.
module dirty_rect_merge_tracker (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  wire  [1:0]         opcode,
    input  drmt_pkg::coord_t   rect_left,
    input  drmt_pkg::coord_t   rect_top,
    input  drmt_pkg::coord_t   rect_right,
    input  drmt_pkg::coord_t   rect_bottom,
    output drmt_pkg::coord_t   out_left,
    output drmt_pkg::coord_t   out_top,
    output drmt_pkg::coord_t   out_right,
    output drmt_pkg::coord_t   out_bottom,
    output logic [4:0]         entry_count,
    output logic               is_entry,
    output logic               last,
    output logic               result_valid
);
    import drmt_pkg::*;

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    drmt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // store, counters, cost unit and output register
    drmt_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rect_left    (rect_left),
        .rect_top     (rect_top),
        .rect_right   (rect_right),
        .rect_bottom  (rect_bottom),
        .status       (status),
        .out_left     (out_left),
        .out_top      (out_top),
        .out_right    (out_right),
        .out_bottom   (out_bottom),
        .entry_count  (entry_count),
        .is_entry     (is_entry),
        .last         (last),
        .result_valid (result_valid)
    );

    // an accepted command always raises busy in the cycle after it is taken
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // a bounding-box beat is always the only beat of its command
    a_box_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !is_entry) |-> last)
        else $error("bounding box beat without last");

    // an entry beat only comes from a non-empty list
    a_entry_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_entry) |-> (entry_count != 5'd0))
        else $error("entry beat with empty list");

    // no beat while a new command could be taken in the same cycle it was launched
    a_no_accept_on_launch: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_box || cmd.emit_entry) |-> busy)
        else $error("emit while idle");

endmodule
`default_nettype wire
